@@ hw/rtl/tcr_pkg.sv @@
// Shared types and fixed constants of the triangle circumradius unit.
// No dependencies.
package tcr_pkg;

	localparam int RADIUS_WIDTH = 24;
	localparam int QUEUE_DEPTH  = 8;
	localparam int MUL_STAGES   = 4;

	typedef logic [RADIUS_WIDTH-1:0] radius_t;

endpackage

@@ hw/rtl/triangle_circumradius_unit.sv @@
// Top level of the triangle circumradius unit: front end, request queue, back end.
// Depends on tcr_pkg, tcr_front, tcr_queue, tcr_back.
//
//  channel   handshake          payload
//  request   push / full        ax ay bx by cx cy  (COORD_WIDTH, signed)
//  result    empty / pop        radius (24, unsigned), degenerate (1)
//
// One request per cycle is taken and one result per cycle given when pop keeps up.
// The path runs through 4 front stages, the queue, two 4-stage multipliers in series,
// 24 radius bit stages (one per radius bit) and the result register.
// full rises when the queue slots are all reserved by requests in flight.
// A result left unpopped stalls the back end; the front end runs on into the queue.
// Reset clears control state only.
module triangle_circumradius_unit #(
	parameter int COORD_WIDTH = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [COORD_WIDTH-1:0] ax,
	input  logic signed [COORD_WIDTH-1:0] ay,
	input  logic signed [COORD_WIDTH-1:0] bx,
	input  logic signed [COORD_WIDTH-1:0] by,
	input  logic signed [COORD_WIDTH-1:0] cx,
	input  logic signed [COORD_WIDTH-1:0] cy,
	output logic                          empty,
	input  logic                          pop,
	output tcr_pkg::radius_t              radius,
	output logic                          degenerate
);

	import tcr_pkg::*;

	localparam int WL = 2*COORD_WIDTH + 1;
	localparam int QW = 1 + 4*WL;

	logic          f_valid, f_deg;
	logic [WL-1:0] f_cross, f_l1, f_l2, f_l3;
	logic          q_pop, q_empty;
	logic [QW-1:0] q_data;

	tcr_front #(.CW(COORD_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.ax(ax), .ay(ay), .bx(bx), .by(by), .cx(cx), .cy(cy),
		.q_pop(q_pop), .out_valid(f_valid), .out_deg(f_deg),
		.out_cross(f_cross), .out_l1(f_l1), .out_l2(f_l2), .out_l3(f_l3)
	);

	tcr_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_en(f_valid), .wr_data({f_deg, f_cross, f_l1, f_l2, f_l3}),
		.rd_en(q_pop), .rd_data(q_data), .empty(q_empty)
	);

	tcr_back #(.CW(COORD_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_empty(q_empty), .q_pop(q_pop),
		.q_deg(q_data[QW-1]),
		.q_cross(q_data[4*WL-1 -: WL]),
		.q_l1(q_data[3*WL-1 -: WL]),
		.q_l2(q_data[2*WL-1 -: WL]),
		.q_l3(q_data[WL-1:0]),
		.pop(pop), .empty(empty), .radius(radius), .degenerate(degenerate)
	);

endmodule

@@ hw/rtl/tcr_mul.sv @@
// Pipelined unsigned multiplier, one digit of b per stage, with sideband carried alongside.
// Depends on nothing; stage count set by the STAGES parameter.
module tcr_mul #(
	parameter int WA     = 16,
	parameter int WB     = 16,
	parameter int SW     = 1,
	parameter int STAGES = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [WA-1:0]     a,
	input  logic [WB-1:0]     b,
	input  logic [SW-1:0]     side_in,
	output logic              out_valid,
	output logic [WA+WB-1:0]  p,
	output logic [SW-1:0]     side_out
);

	localparam int D  = (WB + STAGES - 1) / STAGES;
	localparam int BP = D * STAGES;
	localparam int WP = WA + WB;

	logic [WA-1:0] a_i   [STAGES];
	logic [BP-1:0] b_i   [STAGES];
	logic [WP-1:0] acc_i [STAGES];
	logic [SW-1:0] sd_i  [STAGES];
	logic          v_i   [STAGES];

	logic [WA-1:0] a_s   [STAGES];
	logic [BP-1:0] b_s   [STAGES];
	logic [WP-1:0] acc_s [STAGES];
	logic [SW-1:0] sd_s  [STAGES];
	logic          v_s   [STAGES];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic [WA+D-1:0] pp;

		if (k == 0) begin : g_first
			assign a_i[k]   = a;
			assign b_i[k]   = BP'(b);
			assign acc_i[k] = '0;
			assign sd_i[k]  = side_in;
			assign v_i[k]   = in_valid;
		end else begin : g_next
			assign a_i[k]   = a_s[k-1];
			assign b_i[k]   = b_s[k-1];
			assign acc_i[k] = acc_s[k-1];
			assign sd_i[k]  = sd_s[k-1];
			assign v_i[k]   = v_s[k-1];
		end

		assign pp = a_i[k] * b_i[k][k*D +: D];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_i[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				a_s[k]   <= a_i[k];
				b_s[k]   <= b_i[k];
				acc_s[k] <= acc_i[k] + (WP'(pp) << (k * D));
				sd_s[k]  <= sd_i[k];
			end
		end
	end

	assign out_valid = v_s[STAGES-1];
	assign p         = acc_s[STAGES-1];
	assign side_out  = sd_s[STAGES-1];

endmodule

@@ hw/rtl/tcr_front.sv @@
// Front end: takes point triples, forms edge vectors, cross product and squared side lengths.
// Depends on tcr_pkg; holds the request credit count that drives full.
module tcr_front #(
	parameter int CW = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic signed [CW-1:0] ax,
	input  logic signed [CW-1:0] ay,
	input  logic signed [CW-1:0] bx,
	input  logic signed [CW-1:0] by,
	input  logic signed [CW-1:0] cx,
	input  logic signed [CW-1:0] cy,
	input  logic                 q_pop,
	output logic                 out_valid,
	output logic                 out_deg,
	output logic [2*CW:0]        out_cross,
	output logic [2*CW:0]        out_l1,
	output logic [2*CW:0]        out_l2,
	output logic [2*CW:0]        out_l3
);

	import tcr_pkg::*;

	localparam int WL  = 2*CW + 1;
	localparam int CRW = $clog2(QUEUE_DEPTH + 1);

	logic [CRW-1:0] credit_q;
	logic           take;

	logic          v_s1;
	logic [CW-1:0] ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1;

	logic [CW:0]   ux, uy, vx, vy, wx, wy;
	logic [CW-1:0] mux, muy, mvx, mvy, mwx, mwy;

	logic          v_s2, addsub_s2;
	logic [CW-1:0] mux_s2, muy_s2, mvx_s2, mvy_s2, mwx_s2, mwy_s2;

	logic            v_s3, addsub_s3;
	logic [2*CW-1:0] p_s3, q_s3, sux_s3, suy_s3, svx_s3, svy_s3, swx_s3, swy_s3;

	logic          v_s4;
	logic [WL-1:0] cross_s4, l1_s4, l2_s4, l3_s4;

	// a request needs a free queue slot reserved up front; the pipe never stalls
	assign full = (credit_q == '0);
	assign take = push & ~full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= CRW'(QUEUE_DEPTH);
		end else if (take & ~q_pop) begin
			credit_q <= credit_q - 1'b1;
		end else if (q_pop & ~take) begin
			credit_q <= credit_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1 <= ax;
		ay_s1 <= ay;
		bx_s1 <= bx;
		by_s1 <= by;
		cx_s1 <= cx;
		cy_s1 <= cy;
	end

	assign ux = {bx_s1[CW-1], bx_s1} - {ax_s1[CW-1], ax_s1};
	assign uy = {by_s1[CW-1], by_s1} - {ay_s1[CW-1], ay_s1};
	assign vx = {cx_s1[CW-1], cx_s1} - {ax_s1[CW-1], ax_s1};
	assign vy = {cy_s1[CW-1], cy_s1} - {ay_s1[CW-1], ay_s1};
	assign wx = {cx_s1[CW-1], cx_s1} - {bx_s1[CW-1], bx_s1};
	assign wy = {cy_s1[CW-1], cy_s1} - {by_s1[CW-1], by_s1};

	assign mux = ux[CW] ? CW'(-ux) : ux[CW-1:0];
	assign muy = uy[CW] ? CW'(-uy) : uy[CW-1:0];
	assign mvx = vx[CW] ? CW'(-vx) : vx[CW-1:0];
	assign mvy = vy[CW] ? CW'(-vy) : vy[CW-1:0];
	assign mwx = wx[CW] ? CW'(-wx) : wx[CW-1:0];
	assign mwy = wy[CW] ? CW'(-wy) : wy[CW-1:0];

	always_ff @(posedge clk) begin
		mux_s2    <= mux;
		muy_s2    <= muy;
		mvx_s2    <= mvx;
		mvy_s2    <= mvy;
		mwx_s2    <= mwx;
		mwy_s2    <= mwy;
		// terms of opposite sign: the cross product magnitude is their sum
		addsub_s2 <= (ux[CW] ^ vy[CW]) ^ (vx[CW] ^ uy[CW]);
	end

	always_ff @(posedge clk) begin
		p_s3      <= mux_s2 * mvy_s2;
		q_s3      <= mvx_s2 * muy_s2;
		sux_s3    <= mux_s2 * mux_s2;
		suy_s3    <= muy_s2 * muy_s2;
		svx_s3    <= mvx_s2 * mvx_s2;
		svy_s3    <= mvy_s2 * mvy_s2;
		swx_s3    <= mwx_s2 * mwx_s2;
		swy_s3    <= mwy_s2 * mwy_s2;
		addsub_s3 <= addsub_s2;
	end

	always_ff @(posedge clk) begin
		if (addsub_s3) begin
			cross_s4 <= {1'b0, p_s3} + {1'b0, q_s3};
		end else if (p_s3 >= q_s3) begin
			cross_s4 <= {1'b0, p_s3 - q_s3};
		end else begin
			cross_s4 <= {1'b0, q_s3 - p_s3};
		end
		l1_s4 <= {1'b0, sux_s3} + {1'b0, suy_s3};
		l2_s4 <= {1'b0, swx_s3} + {1'b0, swy_s3};
		l3_s4 <= {1'b0, svx_s3} + {1'b0, svy_s3};
	end

	assign out_valid = v_s4;
	assign out_deg   = (cross_s4 == '0);
	assign out_cross = cross_s4;
	assign out_l1    = l1_s4;
	assign out_l2    = l2_s4;
	assign out_l3    = l3_s4;

endmodule

@@ hw/rtl/tcr_queue.sv @@
// Small register queue between the front end and the back end.
// No package dependency; overflow is prevented by the front end's credit count.
module tcr_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CNW = $clog2(DEPTH + 1);

	logic [W-1:0]   mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNW-1:0] count_q;

	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en & ~rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en & ~wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

@@ hw/rtl/tcr_back.sv @@
// Back end: forms (2*cross)^2 and the product of squared sides, then finds the radius
// one bit per stage. Depends on tcr_pkg and tcr_mul; holds the result register.
module tcr_back #(
	parameter int CW = 20
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_empty,
	output logic                     q_pop,
	input  logic                     q_deg,
	input  logic [2*CW:0]            q_cross,
	input  logic [2*CW:0]            q_l1,
	input  logic [2*CW:0]            q_l2,
	input  logic [2*CW:0]            q_l3,
	input  logic                     pop,
	output logic                     empty,
	output tcr_pkg::radius_t         radius,
	output logic                     degenerate
);

	import tcr_pkg::*;

	localparam int WL  = 2*CW + 1;
	localparam int WT  = 2*WL + 2;
	localparam int W12 = 2*WL;
	localparam int WP  = 3*WL;
	localparam int RW  = RADIUS_WIDTH;
	localparam int WU  = RW + WT;
	localparam int WS  = 2*RW + WT;
	localparam int WX  = (WS > WP) ? WS : WP;

	logic en;
	logic out_v_q;
	radius_t radius_q;
	logic deg_q;

	logic [WT-1:0]  t_a;
	logic           deg_a;
	logic [W12-1:0] l12_a;
	logic [WL-1:0]  l3_a;
	logic           v_a;

	logic [WP-1:0]  p_b;
	logic [WT-1:0]  t_b;
	logic           deg_b;
	logic           v_b;

	logic [RW-1:0] r_i   [RW];
	logic [WS-1:0] sq_i  [RW];
	logic [WU-1:0] u_i   [RW];
	logic [WT-1:0] t_i   [RW];
	logic [WP-1:0] p_i   [RW];
	logic          deg_i [RW];
	logic          v_i   [RW];

	logic [RW-1:0] r_s   [RW];
	logic [WS-1:0] sq_s  [RW];
	logic [WU-1:0] u_s   [RW];
	logic [WT-1:0] t_s   [RW];
	logic [WP-1:0] p_s   [RW];
	logic          deg_s [RW];
	logic          v_s   [RW];

	// the whole back end advances together whenever the result slot is free or leaving
	assign en    = ~out_v_q | pop;
	assign q_pop = en & ~q_empty;

	tcr_mul #(
		.WA(WL + 1), .WB(WL + 1), .SW(1), .STAGES(MUL_STAGES)
	) u_mul_t (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(q_pop),
		.a({q_cross, 1'b0}), .b({q_cross, 1'b0}), .side_in(q_deg),
		.out_valid(), .p(t_a), .side_out(deg_a)
	);

	tcr_mul #(
		.WA(WL), .WB(WL), .SW(WL), .STAGES(MUL_STAGES)
	) u_mul_l12 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(q_pop),
		.a(q_l1), .b(q_l2), .side_in(q_l3),
		.out_valid(v_a), .p(l12_a), .side_out(l3_a)
	);

	tcr_mul #(
		.WA(W12), .WB(WL), .SW(WT + 1), .STAGES(MUL_STAGES)
	) u_mul_p (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_a),
		.a(l12_a), .b(l3_a), .side_in({t_a, deg_a}),
		.out_valid(v_b), .p(p_b), .side_out({t_b, deg_b})
	);

	// keep r^2*T and r*T so each trial bit costs only shifted adds and one compare
	for (genvar i = 0; i < RW; i++) begin : g_root
		localparam int BIT = RW - 1 - i;
		logic [WS-1:0] trial;
		logic          fits;

		if (i == 0) begin : g_first
			assign r_i[i]   = '0;
			assign sq_i[i]  = '0;
			assign u_i[i]   = '0;
			assign t_i[i]   = t_b;
			assign p_i[i]   = p_b;
			assign deg_i[i] = deg_b;
			assign v_i[i]   = v_b;
		end else begin : g_next
			assign r_i[i]   = r_s[i-1];
			assign sq_i[i]  = sq_s[i-1];
			assign u_i[i]   = u_s[i-1];
			assign t_i[i]   = t_s[i-1];
			assign p_i[i]   = p_s[i-1];
			assign deg_i[i] = deg_s[i-1];
			assign v_i[i]   = v_s[i-1];
		end

		assign trial = sq_i[i] + (WS'(u_i[i]) << (BIT + 1)) + (WS'(t_i[i]) << (2 * BIT));
		assign fits  = (WX'(trial) <= WX'(p_i[i]));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_i[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				t_s[i]   <= t_i[i];
				p_s[i]   <= p_i[i];
				deg_s[i] <= deg_i[i];
				if (fits) begin
					r_s[i]  <= r_i[i] | (RW'(1) << BIT);
					sq_s[i] <= trial;
					u_s[i]  <= u_i[i] + (WU'(t_i[i]) << BIT);
				end else begin
					r_s[i]  <= r_i[i];
					sq_s[i] <= sq_i[i];
					u_s[i]  <= u_i[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_s[RW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			radius_q <= r_s[RW-1];
			deg_q    <= deg_s[RW-1];
		end
	end

	assign empty      = ~out_v_q;
	assign radius     = radius_q;
	assign degenerate = deg_q;

endmodule
